[rtl/bda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int VALUE_W    = 32;
	localparam int BCD_DIGITS = 10;
	localparam int DIG_W      = 4;
	localparam int BCD_W      = BCD_DIGITS * DIG_W;
	localparam int POS_W      = $clog2(BCD_DIGITS);
	localparam int CNT_W      = $clog2(VALUE_W + 1);
	localparam int CHAR_W     = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIG_W-1:0]  DAB_LIMIT  = 4'd5;
	localparam logic [DIG_W-1:0]  DAB_ADJUST = 4'd3;

	typedef logic [DIG_W-1:0] bcd_digit_t;
	typedef bcd_digit_t [BCD_DIGITS-1:0] bcd_t;

	// status of a sub-unit toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} bda_stat_t;

endpackage

[rtl/bda_dabble.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_dabble
// Iterative shift and add-3 unit: one bit of the binary value per cycle.
// ----------------------------------------------------------------------------
module bda_dabble (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bda_pkg::VALUE_W-1:0] value,
	output bda_pkg::bda_stat_t          stat,
	output bda_pkg::bcd_t               bcd
);

	logic [bda_pkg::VALUE_W-1:0] bin_q;
	bda_pkg::bcd_t               bcd_q;
	logic [bda_pkg::CNT_W-1:0]   cnt_q;
	logic                        done_q;

	bda_pkg::bcd_t               adj;
	logic [bda_pkg::BCD_W-1:0]   adj_flat;
	logic [bda_pkg::BCD_W-1:0]   bcd_next;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < bda_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[i] >= bda_pkg::DAB_LIMIT) begin
				adj[i] = bcd_q[i] + bda_pkg::DAB_ADJUST;
			end
		end
		adj_flat = adj;
		bcd_next = {adj_flat[bda_pkg::BCD_W-2:0], bin_q[bda_pkg::VALUE_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= bda_pkg::CNT_W'(bda_pkg::VALUE_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bda_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[bda_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

[rtl/bda_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_emit
// Digit emitter: skips leading zeros, then sends one ascii digit per transfer.
// ----------------------------------------------------------------------------
module bda_emit #(
	parameter int DIGITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bda_pkg::bcd_t               bcd,
	output bda_pkg::bda_stat_t          stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bda_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last
);

	logic [bda_pkg::POS_W-1:0]  pos_q;
	logic                       active_q;
	logic                       valid_q;
	logic [bda_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;

	logic [bda_pkg::BCD_DIGITS-1:0] nz_above;
	logic [bda_pkg::POS_W-1:0]      start_pos;
	logic                           load;

	// nz_above[k]: value reaches 10^k
	always_comb begin
		nz_above = '0;
		nz_above[bda_pkg::BCD_DIGITS-1] = (bcd[bda_pkg::BCD_DIGITS-1] != '0);
		for (int j = bda_pkg::BCD_DIGITS - 2; j >= 0; j--) begin
			nz_above[j] = nz_above[j+1] | (bcd[j] != '0);
		end
		start_pos = '0;
		for (int k = 1; k < DIGITS; k++) begin
			if (nz_above[k] && start_pos == '0) begin
				start_pos = bda_pkg::POS_W'(k);
			end
		end
		for (int k = DIGITS - 1; k >= 1; k--) begin
			if (nz_above[k] && start_pos < bda_pkg::POS_W'(k)) begin
				start_pos = bda_pkg::POS_W'(k);
			end
		end
	end

	assign load = active_q && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q  <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				pos_q    <= start_pos;
			end else if (load) begin
				if (pos_q == '0) begin
					active_q <= 1'b0;
				end else begin
					pos_q <= pos_q - 1'b1;
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= bda_pkg::ASCII_ZERO + {2'b00, bcd[pos_q]};
			last_q <= (pos_q == '0);
		end
	end

	assign stat.busy  = active_q;
	assign stat.done  = load && (pos_q == '0);
	assign out_valid  = valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule

[rtl/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// the dabble unit converts a number to bcd, then the emitter sends its digits
// each number gives 1..DIGITS digits; no new number is taken until its last is loaded
// conversion runs the 32 shift/add-3 iterations of the single dabble unit
// digits then leave at one per cycle while out_ready stays high
// reset: arst_n clears the sequencer, counters and output valid at once
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 32-bit unsigned number to its lowest DIGITS decimal ascii digits, msd first.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
	parameter int DIGITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bda_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bda_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic               in_xfer;
	logic               emit_start;
	bda_pkg::bda_stat_t dab_stat;
	bda_pkg::bda_stat_t emit_stat;
	bda_pkg::bcd_t      bcd;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign emit_start = (state_q == ST_CONV) && dab_stat.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (dab_stat.done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_stat.done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	bda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.value  (value),
		.stat   (dab_stat),
		.bcd    (bcd)
	);

	bda_emit #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (emit_start),
		.bcd        (bcd),
		.stat       (emit_stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while a conversion runs");

	a_dabble_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dab_stat.done |-> (state_q == ST_CONV))
		else $error("dabble finished outside conversion");

	a_emit_done_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_stat.done |-> (state_q == ST_EMIT))
		else $error("emitter finished outside emit phase");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(dab_stat.busy && emit_stat.busy))
		else $error("dabble and emitter active together");

endmodule

[test/binary_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Streams 32-bit numbers into the converter and checks every ascii digit and
// last flag against a behavioral expansion of the number into decimal places,
// with the sender idling and the receiver stalling in several patterns.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;

	localparam int DIGITS        = 8;
	localparam int PHASE_ITEMS   = 110;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [bda_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} digit_rec_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic [bda_pkg::VALUE_W-1:0] value     = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [bda_pkg::CHAR_W-1:0]  digit_char;
	logic                        last;

	digit_rec_t pending_digits[$];
	digit_rec_t head_digit;
	int         error_count        = 0;
	int         idle_cycles        = 0;
	int         sender_idle_pct    = 0;
	int         receiver_stall_pct = 0;

	binary_to_decimal_ascii #(
		.DIGITS(DIGITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// expected digits of one number, most significant place first
	function automatic void predict_digits(input logic [bda_pkg::VALUE_W-1:0] v);
		longint unsigned num;
		longint unsigned place;
		digit_rec_t      rec;
		int              k;
		num   = v;
		place = 1;
		for (k = 1; k < DIGITS; k++) begin
			place = place * 10;
		end
		for (k = 1; k < DIGITS; k++) begin
			if (num >= place) begin
				rec.ch   = bda_pkg::CHAR_W'(((num / place) % 10) + bda_pkg::ASCII_ZERO);
				rec.last = 1'b0;
				pending_digits.push_back(rec);
			end
			place = place / 10;
		end
		rec.ch   = bda_pkg::CHAR_W'((num % 10) + bda_pkg::ASCII_ZERO);
		rec.last = 1'b1;
		pending_digits.push_back(rec);
	endfunction

	// result check first, then prediction of a newly accepted number
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_digits.size() == 0) begin
					$display("%0t: unexpected digit, expected none, actual char %0d last %0b",
						$time, digit_char, last);
					error_count++;
				end else begin
					head_digit = pending_digits.pop_front();
					if (digit_char !== head_digit.ch) begin
						$display("%0t: digit_char mismatch, expected %0d, actual %0d",
							$time, head_digit.ch, digit_char);
						error_count++;
					end
					if (last !== head_digit.last) begin
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, head_digit.last, last);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_digits(value);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// valid stays high across back-to-back numbers, dropped for idle cycles and while waiting for digits
	task automatic send_value(input logic [bda_pkg::VALUE_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic wait_for_digits();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
	endtask

	// mix of full-range numbers, numbers of a chosen digit count, and
	// numbers right around a power of ten
	function automatic logic [bda_pkg::VALUE_W-1:0] random_value();
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned span;
		int              width;
		int              k;
		int              sel;
		sel = $urandom_range(3);
		if (sel == 0) begin
			return $urandom;
		end
		if (sel == 1) begin
			lo    = 1;
			width = $urandom_range(9, 1);
			for (k = 0; k < width; k++) begin
				lo = lo * 10;
			end
			return bda_pkg::VALUE_W'(lo - 1 + $urandom_range(2));
		end
		width = $urandom_range(10, 1);
		lo    = 1;
		for (k = 1; k < width; k++) begin
			lo = lo * 10;
		end
		hi = lo * 10 - 1;
		if (width == 1) begin
			lo = 0;
		end
		if (hi > 64'hFFFF_FFFF) begin
			hi = 64'hFFFF_FFFF;
		end
		span = hi - lo + 1;
		return bda_pkg::VALUE_W'(lo + ({$urandom, $urandom} % span));
	endfunction

	task automatic run_random_phase(input int idle_pct, input int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (PHASE_ITEMS) send_value(random_value());
		wait_for_digits();
	endtask

	// zero, place boundaries, numbers too wide for eight places, bit patterns
	task automatic test_directed();
		logic [bda_pkg::VALUE_W-1:0] corner[$] = '{
			32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100,
			32'd9999999, 32'd10000000, 32'd10000001, 32'd12345678,
			32'd99999999, 32'd100000000, 32'd100000001, 32'd10203040,
			32'd90000009, 32'd1000000000, 32'd123456789,
			32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000
		};
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		foreach (corner[i]) begin
			if (i == 11) begin
				wait_for_digits();
			end
			send_value(corner[i]);
		end
		wait_for_digits();
	endtask

	task automatic test_no_idle();
		run_random_phase(0, 0);
	endtask

	task automatic test_sender_idle();
		run_random_phase(60, 0);
	endtask

	task automatic test_receiver_stall();
		run_random_phase(0, 60);
	endtask

	task automatic test_both_idle();
		run_random_phase(6, 6);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_digits.size() != 0) begin
			$display("%0t: digits never arrived, expected %0d more, actual none",
				$time, pending_digits.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
